>>> design/bdt_pkg.sv
// Package with the widths, register indexes, types and helpers of the biased differential threshold.
package bdt_pkg;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_KNEE_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PICKUP_LEVEL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNEE_POINTS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOPE_TABLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INSTANT_LEVEL = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_MODE = 3'd5;

   localparam logic [1:0] SCALE_AS_SET = 2'd0;
   localparam logic [1:0] SCALE_HALVE = 2'd1;
   localparam logic [1:0] SCALE_DOUBLE = 2'd2;

   localparam logic [1:0] RESET_KNEE_COUNT = 2'd1;
   localparam logic [15:0] RESET_PICKUP_LEVEL = 16'd128;
   localparam logic [47:0] RESET_KNEE_POINTS = 48'd219043332352256;
   localparam logic [63:0] RESET_SLOPE_TABLE = 64'd1844699694787084288;
   localparam logic [15:0] RESET_INSTANT_LEVEL = 16'd1280;
   localparam logic [1:0] RESET_SCALE_MODE = 2'd0;

   localparam int ACC_W = 34;
   localparam int SLOPE_FRAC = 14;
   localparam logic [ACC_W-1:0] ROUND_HALF = 34'd8192;
   localparam logic [15:0] SAT_MAX = 16'hFFFF;

   typedef logic [16:0] scaled_type;

   typedef struct packed {
      logic [1:0] seg;
      logic last;
      logic [15:0] diff;
      logic [15:0] len0;
      logic [15:0] len1;
      logic [15:0] len2;
   } seg_info_type;

   function automatic scaled_type scale_value(input logic [1:0] mode, input logic [15:0] v);
      scaled_type r;
      unique case (mode)
         SCALE_HALVE: r = {2'b00, v[15:1]};
         SCALE_DOUBLE: r = {v, 1'b0};
         default: r = {1'b0, v};
      endcase
      return r;
   endfunction

endpackage

>>> design/bdt_req_if.sv
// Input channel interface carrying one restraint current item.
interface bdt_req_if;
   logic valid;
   logic ready;
   logic signed [16:0] restraint_current;

   modport source(output valid, output restraint_current, input ready);
   modport sink(input valid, input restraint_current, output ready);
endinterface

>>> design/bdt_rsp_if.sv
// Result channel interface carrying one operating threshold item.
interface bdt_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] operating_threshold;
   logic [1:0] segment;
   logic limited;

   modport source(output valid, output operating_threshold, output segment, output limited,
                  input ready);
   modport sink(input valid, input operating_threshold, input segment, input limited,
                output ready);
endinterface

>>> design/bdt_locate.sv
// Segment locator: scales the knees and finds the segment, segment lengths and remainder.
module bdt_locate (
   input  logic [16:0]              raw,
   input  logic [1:0]               knee_count,
   input  logic [47:0]              knee_points,
   input  logic [1:0]               scale_mode,
   output bdt_pkg::seg_info_type    info
);
   import bdt_pkg::*;

   scaled_type k0, k1, k2;
   scaled_type e0, e1, e2;
   scaled_type r;
   scaled_type prev;
   scaled_type d01, d12, dr;
   logic [1:0] knees;
   logic neg;
   logic c0, c1, c2;
   logic [1:0] seg;

   always_comb begin
      k0 = scale_value(scale_mode, knee_points[15:0]);
      k1 = scale_value(scale_mode, knee_points[31:16]);
      k2 = scale_value(scale_mode, knee_points[47:32]);
      e0 = k0;
      e1 = (k1 < e0) ? e0 : k1;
      e2 = (k2 < e1) ? e1 : k2;
      knees = (knee_count == 2'd0) ? 2'd1 : knee_count;
      neg = raw[16];
      r = {1'b0, raw[15:0]};
      c0 = !neg && (r > e0);
      c1 = c0 && (knees >= 2'd2) && (r > e1);
      c2 = c1 && (knees == 2'd3) && (r > e2);
      if (c2) begin
         seg = 2'd3;
         prev = e2;
      end else if (c1) begin
         seg = 2'd2;
         prev = e1;
      end else if (c0) begin
         seg = 2'd1;
         prev = e0;
      end else begin
         seg = 2'd0;
         prev = '0;
      end
      d01 = e1 - e0;
      d12 = e2 - e1;
      dr = r - prev;
      info.seg = seg;
      info.last = (seg == knees);
      info.diff = neg ? 16'd0 : dr[15:0];
      info.len0 = c0 ? e0[15:0] : 16'd0;
      info.len1 = c1 ? d01[15:0] : 16'd0;
      info.len2 = c2 ? d12[15:0] : 16'd0;
   end

endmodule

>>> design/biased_differential_threshold.sv
// Top level of the biased differential threshold: configuration registers and the pipeline.
// The block takes one restraint current item per cycle while the result is not stalled and
// returns its threshold item through five register stages: segment location, four parallel
// 16 by 16 bit slope products, the sum of those products, rounding plus the scaled pickup, and
// the instant limit with saturation. Each stage holds its item while the stage after it is full
// and cannot advance, so a stalled result blocks new items only once every stage is occupied.
module biased_differential_threshold (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [bdt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bdt_pkg::CSR_DATA_W-1:0]     csr_wdata,
   bdt_req_if.sink                            req_chan,
   bdt_rsp_if.source                          rsp_chan
);
   import bdt_pkg::*;

   logic [1:0] knee_count_ff;
   logic [15:0] pickup_level_ff;
   logic [47:0] knee_points_ff;
   logic [63:0] slope_table_ff;
   logic [15:0] instant_level_ff;
   logic [1:0] scale_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         knee_count_ff <= RESET_KNEE_COUNT;
         pickup_level_ff <= RESET_PICKUP_LEVEL;
         knee_points_ff <= RESET_KNEE_POINTS;
         slope_table_ff <= RESET_SLOPE_TABLE;
         instant_level_ff <= RESET_INSTANT_LEVEL;
         scale_mode_ff <= RESET_SCALE_MODE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KNEE_COUNT: knee_count_ff <= csr_wdata[1:0];
            CSR_PICKUP_LEVEL: pickup_level_ff <= csr_wdata[15:0];
            CSR_KNEE_POINTS: knee_points_ff <= csr_wdata[47:0];
            CSR_SLOPE_TABLE: slope_table_ff <= csr_wdata;
            CSR_INSTANT_LEVEL: instant_level_ff <= csr_wdata[15:0];
            CSR_SCALE_MODE: scale_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   assign adv5 = !v5_ff || rsp_chan.ready;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_chan.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_chan.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
      end
   end

   seg_info_type info_in, info_ff;

   bdt_locate u_locate (
      .raw(req_chan.restraint_current),
      .knee_count(knee_count_ff),
      .knee_points(knee_points_ff),
      .scale_mode(scale_mode_ff),
      .info(info_in)
   );

   always_ff @(posedge clock) begin
      if (adv1) info_ff <= info_in;
   end

   logic [15:0] slope_sel;
   logic [31:0] m0_in, m1_in, m2_in, m3_in;
   logic [31:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic [1:0] seg2_ff;
   logic last2_ff;

   always_comb begin
      unique case (info_ff.seg)
         2'd0: slope_sel = slope_table_ff[15:0];
         2'd1: slope_sel = slope_table_ff[31:16];
         2'd2: slope_sel = slope_table_ff[47:32];
         default: slope_sel = slope_table_ff[63:48];
      endcase
      m0_in = 32'(info_ff.len0) * 32'(slope_table_ff[15:0]);
      m1_in = 32'(info_ff.len1) * 32'(slope_table_ff[31:16]);
      m2_in = 32'(info_ff.len2) * 32'(slope_table_ff[47:32]);
      m3_in = 32'(info_ff.diff) * 32'(slope_sel);
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         m0_ff <= m0_in;
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         m3_ff <= m3_in;
         seg2_ff <= info_ff.seg;
         last2_ff <= info_ff.last;
      end
   end

   logic [ACC_W-1:0] acc_in, acc_ff;
   logic [1:0] seg3_ff;
   logic last3_ff;

   assign acc_in = ACC_W'(m0_ff) + ACC_W'(m1_ff) + ACC_W'(m2_ff) + ACC_W'(m3_ff);

   always_ff @(posedge clock) begin
      if (adv3) begin
         acc_ff <= acc_in;
         seg3_ff <= seg2_ff;
         last3_ff <= last2_ff;
      end
   end

   logic [ACC_W-1:0] rounded;
   logic [20:0] y_in, y_ff;
   logic [1:0] seg4_ff;
   logic last4_ff;

   always_comb begin
      rounded = (acc_ff + ROUND_HALF) >> SLOPE_FRAC;
      y_in = 21'(scale_value(scale_mode_ff, pickup_level_ff)) + rounded[20:0];
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         y_ff <= y_in;
         seg4_ff <= seg3_ff;
         last4_ff <= last3_ff;
      end
   end

   logic [15:0] thr_in, thr_ff;
   logic lim_in, lim_ff;
   logic [1:0] seg5_ff;
   logic last5_ff;

   always_comb begin
      priority if (last4_ff && (y_ff >= 21'(instant_level_ff))) begin
         thr_in = instant_level_ff;
         lim_in = 1'b1;
      end else if (y_ff > 21'(SAT_MAX)) begin
         thr_in = SAT_MAX;
         lim_in = 1'b1;
      end else begin
         thr_in = y_ff[15:0];
         lim_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         thr_ff <= thr_in;
         lim_ff <= lim_in;
         seg5_ff <= seg4_ff;
         last5_ff <= last4_ff;
      end
   end

   assign rsp_chan.valid = v5_ff;
   assign rsp_chan.operating_threshold = thr_ff;
   assign rsp_chan.segment = seg5_ff;
   assign rsp_chan.limited = lim_ff;

   a_full_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while every stage is full and the output is stalled");

   a_limit_outside_last_is_saturation: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && lim_ff && !last5_ff) |-> (thr_ff == SAT_MAX))
      else $error("limited item outside the last segment is not saturated");

   a_reset_empties_pipeline: assert property (@(posedge clock)
      reset |=> (!v1_ff && !v2_ff && !v3_ff && !v4_ff && !v5_ff))
      else $error("pipeline holds an item after reset");

endmodule

>>> dv/testbench.sv
// Testbench of the biased differential threshold with its own threshold predictor and checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bdt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SLOPE_SHIFT = 14;
   localparam logic [39:0] HALF_LSB = 40'd8192;
   localparam logic [1:0] SCALE_RESERVED = 2'd3;

   typedef enum {SETTING_ALL_ZERO, SETTING_ALL_ONES, SETTING_RANDOM} setting_style_type;

   typedef struct packed {
      logic [16:0] restraint;
      logic [15:0] operating_threshold;
      logic [1:0] segment;
      logic limited;
   } threshold_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bdt_req_if req_bus();
   bdt_rsp_if rsp_bus();

   biased_differential_threshold i_dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   logic [1:0] set_knee_count = RESET_KNEE_COUNT;
   logic [15:0] set_pickup = RESET_PICKUP_LEVEL;
   logic [47:0] set_knees = RESET_KNEE_POINTS;
   logic [63:0] set_slopes = RESET_SLOPE_TABLE;
   logic [15:0] set_instant = RESET_INSTANT_LEVEL;
   logic [1:0] set_scale = RESET_SCALE_MODE;

   threshold_item_type expected_thresholds[$];
   int mismatches = 0;
   int items_sent = 0;
   int settings_applied = 0;
   int thresholds_checked = 0;
   int limited_seen = 0;
   int segment_seen[4] = '{0, 0, 0, 0};
   int cycles = 0;
   bit sender_idles = 1'b0;
   bit receiver_idles = 1'b0;
   int rsp_hold_cycles = 0;

   always #6 clock = ~clock;

   function automatic logic [16:0] scaled_setting(input logic [15:0] v);
      logic [16:0] widened;
      widened = {1'b0, v};
      if (set_scale == SCALE_HALVE) begin
         scaled_setting = widened >> 1;
      end else if (set_scale == SCALE_DOUBLE) begin
         scaled_setting = widened << 1;
      end else begin
         scaled_setting = widened;
      end
   endfunction

   function automatic threshold_item_type predict_threshold(input logic [16:0] restraint);
      threshold_item_type r;
      logic [1:0] knees_used;
      logic [16:0] pickup_scaled;
      logic [16:0] knee_at[3];
      logic [16:0] seg_start;
      logic [16:0] current;
      logic [39:0] area;
      logic [39:0] level;
      logic [1:0] seg;
      logic stop;
      knees_used = (set_knee_count == 2'd0) ? 2'd1 : set_knee_count;
      pickup_scaled = scaled_setting(set_pickup);
      for (int i = 0; i < 3; i++) begin
         knee_at[i] = scaled_setting(set_knees[16*i +: 16]);
         if (i > 0 && knee_at[i] < knee_at[i-1]) begin
            knee_at[i] = knee_at[i-1];
         end
      end
      r = '0;
      r.restraint = restraint;
      seg = 2'd0;
      stop = 1'b0;
      area = '0;
      seg_start = '0;
      if (restraint[16]) begin
         level = 40'(pickup_scaled);
      end else begin
         current = {1'b0, restraint[15:0]};
         for (int i = 0; i < 3; i++) begin
            if (!stop && i < int'(knees_used)) begin
               if (current <= knee_at[i]) begin
                  stop = 1'b1;
               end else begin
                  area = area + 40'(knee_at[i] - seg_start) * 40'(set_slopes[16*i +: 16]);
                  seg_start = knee_at[i];
                  seg = 2'(i + 1);
               end
            end
         end
         area = area + 40'(current - seg_start) * 40'(set_slopes[16*seg +: 16]);
         level = 40'(pickup_scaled) + ((area + HALF_LSB) >> SLOPE_SHIFT);
         if (seg == knees_used && level >= 40'(set_instant)) begin
            level = 40'(set_instant);
            r.limited = 1'b1;
         end
      end
      if (level > 40'hFFFF) begin
         level = 40'hFFFF;
         r.limited = 1'b1;
      end
      r.operating_threshold = level[15:0];
      r.segment = seg;
      return r;
   endfunction

   function automatic logic [16:0] pick_restraint();
      int near;
      int widest;
      int top;
      int k;
      logic [16:0] rc;
      widest = 0;
      for (int i = 0; i < 3; i++) begin
         if (int'(scaled_setting(set_knees[16*i +: 16])) > widest) begin
            widest = int'(scaled_setting(set_knees[16*i +: 16]));
         end
      end
      case ($urandom_range(0, 7))
         0: rc = 17'($urandom);
         1: rc = {1'b1, 16'($urandom)};
         2, 3: begin
            k = $urandom_range(0, 2);
            near = int'(scaled_setting(set_knees[16*k +: 16])) + int'($urandom_range(0, 6)) - 3;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            rc = {1'b0, 16'(near)};
         end
         default: begin
            top = widest + widest / 2 + 256;
            if (top > 65535) top = 65535;
            rc = {1'b0, 16'($urandom_range(0, top))};
         end
      endcase
      return rc;
   endfunction

   task automatic send_restraint(input logic [16:0] rc);
      if (sender_idles && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.restraint_current <= rc;
      do @(posedge clock); while (!req_bus.ready);
      expected_thresholds.push_back(predict_threshold(rc));
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_thresholds.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [1:0] knee_count, input logic [15:0] pickup,
                                 input logic [47:0] knees, input logic [63:0] slopes,
                                 input logic [15:0] instant, input logic [1:0] scale);
      wait_for_results();
      write_register(CSR_KNEE_COUNT, 64'(knee_count));
      write_register(CSR_PICKUP_LEVEL, 64'(pickup));
      write_register(CSR_KNEE_POINTS, 64'(knees));
      write_register(CSR_SLOPE_TABLE, slopes);
      write_register(CSR_INSTANT_LEVEL, 64'(instant));
      write_register(CSR_SCALE_MODE, 64'(scale));
      csr_we <= 1'b0;
      set_knee_count = knee_count;
      set_pickup = pickup;
      set_knees = knees;
      set_slopes = slopes;
      set_instant = instant;
      set_scale = scale;
      settings_applied++;
   endtask

   task automatic test_reset_values();
      send_restraint(17'h00000);
      send_restraint(17'h10000);
      send_restraint(17'h1FFFF);
      send_restraint(17'h0FFFF);
      send_restraint(17'h00100);
      send_restraint(17'h00500);
   endtask

   task automatic test_segment_walk();
      apply_settings(2'd3, 16'h0080, {16'h0600, 16'h0300, 16'h0100},
                     {16'h8000, 16'h4000, 16'h2000, 16'h1000}, 16'h2000, SCALE_AS_SET);
      send_restraint(17'h00000);
      send_restraint(17'h00100);
      send_restraint(17'h00101);
      send_restraint(17'h00300);
      send_restraint(17'h00301);
      send_restraint(17'h00600);
      send_restraint(17'h00601);
      send_restraint(17'h0FFFF);
   endtask

   task automatic test_special_cases();
      // A knee count of zero behaves as a single knee.
      apply_settings(2'd0, 16'h0080, {16'h0600, 16'h0300, 16'h0100},
                     {16'h8000, 16'h4000, 16'h2000, 16'h1000}, 16'h0400, SCALE_AS_SET);
      send_restraint(17'h00200);
      send_restraint(17'h00700);
      apply_settings(2'd3, 16'h0081, {16'h0600, 16'h0300, 16'h0100},
                     {16'h8000, 16'h4000, 16'h2000, 16'h1000}, 16'h2000, SCALE_HALVE);
      send_restraint(17'h00181);
      apply_settings(2'd3, 16'h0081, {16'h0600, 16'h0300, 16'h0100},
                     {16'h8000, 16'h4000, 16'h2000, 16'h1000}, 16'h2000, SCALE_DOUBLE);
      send_restraint(17'h00201);
      apply_settings(2'd3, 16'h0081, {16'h0600, 16'h0300, 16'h0100},
                     {16'h8000, 16'h4000, 16'h2000, 16'h1000}, 16'h2000, SCALE_RESERVED);
      send_restraint(17'h00101);
      // The third knee lies below the second, so its segment is empty.
      apply_settings(2'd3, 16'h0040, {16'h0100, 16'h0400, 16'h0200},
                     {16'h8000, 16'h4000, 16'h2000, 16'h1000}, 16'h3000, SCALE_AS_SET);
      send_restraint(17'h00300);
      send_restraint(17'h00500);
      apply_settings(2'd1, 16'hFFFF, {16'hFFFF, 16'hFFFF, 16'hFFFF},
                     {4{16'hFFFF}}, 16'hFFFF, SCALE_DOUBLE);
      send_restraint(17'h10000);
      send_restraint(17'h00001);
      // A threshold that reaches the instantaneous level exactly is clamped.
      apply_settings(2'd1, 16'h0000, {16'h0000, 16'h0000, 16'h0100},
                     {16'h0000, 16'h0000, 16'h4000, 16'h4000}, 16'h0300, SCALE_AS_SET);
      send_restraint(17'h002FF);
      send_restraint(17'h00300);
   endtask

   task automatic test_backpressure_fill();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      apply_settings(2'd2, 16'h0100, {16'h0000, 16'h0800, 16'h0200},
                     {16'h0000, 16'h6000, 16'h3000, 16'h1000}, 16'h1800, SCALE_AS_SET);
      rsp_hold_cycles = 60;
      repeat (24) send_restraint(pick_restraint());
      wait_for_results();
   endtask

   task automatic test_random_phase(input setting_style_type style, input int n_items,
                                    input bit last_phase);
      logic [1:0] kc;
      logic [15:0] pk;
      logic [15:0] k1;
      logic [15:0] k2;
      logic [15:0] k3;
      logic [63:0] sl;
      logic [15:0] inst;
      logic [1:0] sc;
      kc = 2'($urandom_range(0, 3));
      pk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
      case ($urandom_range(0, 3))
         0: begin
            k1 = 16'($urandom);
            k2 = 16'($urandom);
            k3 = 16'($urandom);
         end
         1: begin
            k1 = 16'($urandom_range(0, 8000));
            k2 = 16'($urandom_range(0, 8000));
            k3 = 16'($urandom_range(0, 8000));
         end
         default: begin
            k1 = 16'($urandom_range(16, 6000));
            k2 = k1 + 16'($urandom_range(0, 6000));
            k3 = k2 + 16'($urandom_range(0, 12000));
         end
      endcase
      for (int i = 0; i < 4; i++) begin
         sl[16*i +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 16'h6000));
      end
      inst = ($urandom_range(0, 3) == 0) ? 16'($urandom) : pk + 16'($urandom_range(256, 8192));
      sc = 2'($urandom_range(0, 3));
      if (style == SETTING_ALL_ZERO) begin
         apply_settings(2'd0, 16'h0000, 48'h0, 64'h0, 16'h0000, SCALE_AS_SET);
      end else if (style == SETTING_ALL_ONES) begin
         apply_settings(2'd3, 16'hFFFF, {3{16'hFFFF}}, {4{16'hFFFF}}, 16'hFFFF, SCALE_RESERVED);
      end else begin
         apply_settings(kc, pk, {k3, k2, k1}, sl, inst, sc);
      end
      sender_idles = !last_phase && ($urandom_range(0, 3) != 0);
      receiver_idles = !last_phase && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < n_items; n++) begin
         if (n == n_items / 2 && $urandom_range(0, 1) == 1) begin
            wait_for_results();
         end
         send_restraint(pick_restraint());
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.restraint_current = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_segment_walk();
      test_special_cases();
      test_backpressure_fill();
      test_random_phase(SETTING_ALL_ZERO, 50, 1'b0);
      test_random_phase(SETTING_ALL_ONES, 50, 1'b0);
      for (int p = 0; p < 9; p++) begin
         test_random_phase(SETTING_RANDOM, 50, 1'b0);
      end
      test_random_phase(SETTING_RANDOM, 50, 1'b1);
      wait_for_results();
      repeat (20) @(posedge clock);
      $display("Sent %0d restraint items under %0d register settings, %0d thresholds checked.",
               items_sent, settings_applied, thresholds_checked);
      $display("Results per segment %0d/%0d/%0d/%0d, %0d of them clamped or saturated.",
               segment_seen[0], segment_seen[1], segment_seen[2], segment_seen[3], limited_seen);
      if (mismatches == 0 && expected_thresholds.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_cycles > 0) begin
            hold = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else if (receiver_idles && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_thresholds
      threshold_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_thresholds.size() == 0) begin
            $display("%0t: unexpected threshold item, expected none, actual %h seg %0d lim %0d",
                     $realtime, rsp_bus.operating_threshold, rsp_bus.segment, rsp_bus.limited);
            mismatches++;
         end else begin
            want = expected_thresholds.pop_front();
            thresholds_checked++;
            segment_seen[rsp_bus.segment]++;
            if (rsp_bus.limited) limited_seen++;
            if (rsp_bus.operating_threshold !== want.operating_threshold) begin
               $display("%0t: restraint %h threshold expected %h, actual %h", $realtime,
                        want.restraint, want.operating_threshold, rsp_bus.operating_threshold);
               mismatches++;
            end
            if (rsp_bus.segment !== want.segment) begin
               $display("%0t: restraint %h segment expected %0d, actual %0d", $realtime,
                        want.restraint, want.segment, rsp_bus.segment);
               mismatches++;
            end
            if (rsp_bus.limited !== want.limited) begin
               $display("%0t: restraint %h limited expected %0d, actual %0d", $realtime,
                        want.restraint, want.limited, rsp_bus.limited);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d thresholds outstanding.",
                  cycles, expected_thresholds.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
